@@ design/key_parent_name_hash_table_top_assert.svh @@
// assertion macros shared by the checker of the hash table block
// no dependencies
`ifndef KEY_PARENT_NAME_HASH_TABLE_TOP_ASSERT_SVH
`define KEY_PARENT_NAME_HASH_TABLE_TOP_ASSERT_SVH

// plain property under the block clock and reset
`define KPNHT_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("kpnht assertion failed");

// same-cycle implication
`define KPNHT_ASSERT_IMP(lbl, ck, rn, a, c) \
    `KPNHT_ASSERT(lbl, ck, rn, (a) |-> (c))

// next-cycle implication
`define KPNHT_ASSERT_NXT(lbl, ck, rn, a, c) \
    `KPNHT_ASSERT(lbl, ck, rn, (a) |=> (c))

`endif

@@ design/kpnht_pkg.sv @@
// types and codes of the key, parent and name hash table
// no dependencies
package kpnht_pkg;

    // one table slot
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] parent;
        logic [63:0] name_lo;
        logic [47:0] name_hi;
    } entry_t;

    // request functions
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_SET    = 2'd2;
    localparam logic [1:0] FUNC_WALK   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_COMP    = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;
    localparam logic [1:0] KIND_TRUNC   = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_ZEROKEY  = 2'd3;

    // configuration registers
    localparam logic CFG_ROOT  = 1'b0;
    localparam logic CFG_DEPTH = 1'b1;

    localparam logic [3:0] MAX_DEPTH = 4'd10;
    localparam int         CHAIN_LEN = 11;

endpackage

@@ design/kpnht_if.sv @@
// request and result channel interfaces of the hash table block
// no dependencies
interface kpnht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] parent_in;
    logic [63:0] name_low_in;
    logic [47:0] name_high_in;

    modport source (output valid, func, key, parent_in, name_low_in, name_high_in,
                    input ready);
    modport sink (input valid, func, key, parent_in, name_low_in, name_high_in,
                  output ready);
endinterface

interface kpnht_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] parent_out;
    logic [63:0] name_low_out;
    logic [47:0] name_high_out;
    logic        last;

    modport source (output valid, kind, status, parent_out, name_low_out,
                    name_high_out, last, input ready);
    modport sink (input valid, kind, status, parent_out, name_low_out,
                  name_high_out, last, output ready);
endinterface

@@ design/key_parent_name_hash_table_top.sv @@
// Linear probing hash table of keys with a parent key and a 14-byte name each.
// After reset the block clears every slot of its slot memory and takes
// no request meanwhile. One request at a time: insert, lookup and set probe
// slots from the key's home slot, and one with a zero key is answered without
// probing. A path walk takes the request, probes the slots of every ancestor,
// sends a marker when it meets an unknown or zero key or is truncated, then
// delivers the names and a closing status. A result is held until rsp.ready. The
// single slot memory, read one slot a cycle, sets the rate. Depends on
// kpnht_pkg and kpnht_if.
module key_parent_name_hash_table_top #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    kpnht_req_if.sink   req,
    kpnht_rsp_if.source rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    import kpnht_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PROBE = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_ONE   = 3'd5;

    // slot memory
    entry_t mem [TABLE_SIZE];
    entry_t rdata;
    logic   mem_we;
    logic [IW-1:0] mem_waddr;
    entry_t mem_wdata;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW:0]   used_reg, used_next;
    logic [1:0]    func_reg, func_next;
    logic [31:0]   cur_reg, cur_next;
    logic [31:0]   par_reg, par_next;
    logic [63:0]   nlo_reg, nlo_next;
    logic [47:0]   nhi_reg, nhi_next;
    logic [3:0]    lev_reg, lev_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [1:0]    marker_reg, marker_next;
    logic [1:0]    stat_reg, stat_next;
    logic [31:0]   root_reg;
    logic [3:0]    depth_reg;
    logic [3:0]    limit;

    // ancestor names of a walk
    logic [63:0] chain_lo [CHAIN_LEN];
    logic [47:0] chain_hi [CHAIN_LEN];
    logic        chain_we;

    // output register
    logic        ov_reg;
    logic [1:0]  okind_reg, ostat_reg;
    logic [31:0] opar_reg;
    logic [63:0] onlo_reg;
    logic [47:0] onhi_reg;
    logic        olast_reg;
    logic        out_free, emit;
    logic [1:0]  e_kind, e_stat;
    logic [31:0] e_par;
    logic [63:0] e_nlo;
    logic [47:0] e_nhi;
    logic        e_last;

    logic        accept, empty, hit;

    assign accept   = req.valid & req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free = ~ov_reg | rsp.ready;
    assign limit    = (depth_reg > MAX_DEPTH) ? MAX_DEPTH : depth_reg;
    assign empty    = (rdata.key == 32'd0);
    assign hit      = (rdata.key == cur_reg);

    assign rsp.valid         = ov_reg;
    assign rsp.kind          = okind_reg;
    assign rsp.status        = ostat_reg;
    assign rsp.parent_out    = opar_reg;
    assign rsp.name_low_out  = onlo_reg;
    assign rsp.name_high_out = onhi_reg;
    assign rsp.last          = olast_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        used_next   = used_reg;
        func_next   = func_reg;
        cur_next    = cur_reg;
        par_next    = par_reg;
        nlo_next    = nlo_reg;
        nhi_next    = nhi_reg;
        lev_next    = lev_reg;
        cnt_next    = cnt_reg;
        marker_next = marker_reg;
        stat_next   = stat_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = '0;
        chain_we    = 1'b0;
        emit        = 1'b0;
        e_kind      = KIND_STATUS;
        e_stat      = STAT_OK;
        e_par       = '0;
        e_nlo       = '0;
        e_nhi       = '0;
        e_last      = 1'b0;
        case (state_reg)
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IW'(TABLE_SIZE - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next   = req.func;
                    cur_next    = req.key;
                    par_next    = req.parent_in;
                    nlo_next    = req.name_low_in;
                    nhi_next    = req.name_high_in;
                    lev_next    = '0;
                    cnt_next    = '0;
                    marker_next = KIND_STATUS;
                    idx_next    = req.key[IW-1:0];
                    if (req.func == FUNC_WALK)
                    begin
                        if (req.key == root_reg)
                            state_next = ST_MARK;
                        else if (req.key == 32'd0)
                        begin
                            marker_next = KIND_UNKNOWN;
                            state_next  = ST_MARK;
                        end
                        else
                            state_next = ST_PROBE;
                    end
                    else if (req.key == 32'd0)
                    begin
                        stat_next  = STAT_ZEROKEY;
                        state_next = ST_ONE;
                    end
                    else
                        state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (!empty && !hit)
                    idx_next = idx_reg + 1'b1;
                else if (func_reg == FUNC_WALK)
                begin
                    if (empty)
                    begin
                        marker_next = KIND_UNKNOWN;
                        state_next  = ST_MARK;
                    end
                    else if (lev_reg > limit)
                    begin
                        marker_next = KIND_TRUNC;
                        state_next  = ST_MARK;
                    end
                    else
                    begin
                        chain_we = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        lev_next = lev_reg + 1'b1;
                        cur_next = rdata.parent;
                        idx_next = rdata.parent[IW-1:0];
                        if (rdata.parent == root_reg)
                            state_next = ST_MARK;
                        else if (rdata.parent == 32'd0)
                        begin
                            marker_next = KIND_UNKNOWN;
                            state_next  = ST_MARK;
                        end
                    end
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                    if (hit)
                    begin
                        if (func_reg == FUNC_SET)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '{key: cur_reg, parent: par_reg,
                                          name_lo: nlo_reg, name_hi: nhi_reg};
                            e_par = par_reg;
                            e_nlo = nlo_reg;
                            e_nhi = nhi_reg;
                        end
                        else
                        begin
                            e_par = rdata.parent;
                            e_nlo = rdata.name_lo;
                            e_nhi = rdata.name_hi;
                        end
                    end
                    else if (func_reg == FUNC_INSERT)
                    begin
                        if (used_reg >= (IW+1)'(TABLE_SIZE - 1))
                            e_stat = STAT_FULL;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '{key: cur_reg, parent: 32'd0,
                                          name_lo: 64'd0, name_hi: 48'd0};
                            used_next = used_reg + 1'b1;
                        end
                    end
                    else
                        e_stat = STAT_NOTFOUND;
                end
            end
            ST_MARK:
            begin
                if (marker_reg == KIND_STATUS)
                    state_next = ST_EMIT;
                else if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = marker_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (cnt_reg == 4'd0)
                    begin
                        e_last     = 1'b1;
                        e_stat     = (marker_reg == KIND_UNKNOWN) ? STAT_NOTFOUND : STAT_OK;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        e_kind   = KIND_COMP;
                        e_nlo    = chain_lo[cnt_reg - 1'b1];
                        e_nhi    = chain_hi[cnt_reg - 1'b1];
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            ST_ONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_stat     = stat_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // slot memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata <= mem[idx_next];
    end

    // walk name store
    always_ff @(posedge clk)
    begin
        if (chain_we)
        begin
            chain_lo[cnt_reg] <= rdata.name_lo;
            chain_hi[cnt_reg] <= rdata.name_hi;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            clr_reg    <= '0;
            used_reg   <= '0;
            ov_reg     <= 1'b0;
            root_reg   <= 32'd2;
            depth_reg  <= MAX_DEPTH;
            marker_reg <= KIND_STATUS;
            cnt_reg    <= '0;
            lev_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            used_reg   <= used_next;
            ov_reg     <= emit | (ov_reg & ~rsp.ready);
            marker_reg <= marker_next;
            cnt_reg    <= cnt_next;
            lev_reg    <= lev_next;
            if (cfg_we && cfg_index == CFG_ROOT)
                root_reg <= cfg_wdata;
            if (cfg_we && cfg_index == CFG_DEPTH)
                depth_reg <= cfg_wdata[3:0];
        end
    end

    // request payload and result register
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        func_reg <= func_next;
        cur_reg  <= cur_next;
        par_reg  <= par_next;
        nlo_reg  <= nlo_next;
        nhi_reg  <= nhi_next;
        stat_reg <= stat_next;
        if (emit)
        begin
            okind_reg <= e_kind;
            ostat_reg <= e_stat;
            opar_reg  <= e_par;
            onlo_reg  <= e_nlo;
            onhi_reg  <= e_nhi;
            olast_reg <= e_last;
        end
    end

endmodule

@@ design/kpnht_checker.sv @@
// port checker of the hash table block, bound to the top level
// depends on kpnht_pkg and key_parent_name_hash_table_top_assert.svh
`include "key_parent_name_hash_table_top_assert.svh"

module kpnht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_kind,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_parent_out,
    input logic        rsp_last
);
    import kpnht_pkg::*;

    logic side_valid;
    logic side_clean;

    // a marker or component on the result port
    assign side_valid = rsp_valid && (rsp_kind != KIND_STATUS);
    assign side_clean = (rsp_status == STAT_OK) && (rsp_parent_out == 32'd0);

    // a stalled result stays
    `KPNHT_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    // a stalled result keeps its kind
    `KPNHT_ASSERT_NXT(a_rsp_kind_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_kind))
    // markers and components never end a request
    `KPNHT_ASSERT_IMP(a_last_status, clk, rst_n, side_valid, !rsp_last)
    // markers and components carry no status and no parent
    `KPNHT_ASSERT_IMP(a_comp_clean, clk, rst_n, side_valid, side_clean)
endmodule

bind key_parent_name_hash_table_top kpnht_checker u_kpnht_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_kind       (rsp.kind),
    .rsp_status     (rsp.status),
    .rsp_parent_out (rsp.parent_out),
    .rsp_last       (rsp.last)
);

@@ dv/tb_key_parent_name_hash_table_top.sv @@
// testbench of the linear probing hash table block: directed table, then random requests
// expected results come from a behavioral table kept in the testbench
// depends on kpnht_pkg, kpnht_if and key_parent_name_hash_table_top
`timescale 1ns / 1ps

module tb_key_parent_name_hash_table_top;
    import kpnht_pkg::*;

    localparam int TSIZE = 4096;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] parent;
        logic [63:0] nlo;
        logic [47:0] nhi;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] parent;
        logic [63:0] nlo;
        logic [47:0] nhi;
        logic        has_exp;
        result_t     exp;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [31:0] cfg_wdata;

    kpnht_req_if req ();
    kpnht_rsp_if rsp ();

    key_parent_name_hash_table_top #(.TABLE_SIZE(TSIZE)) dut (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // shadow table state
    logic [31:0] sh_key [TSIZE];
    logic [31:0] sh_par [TSIZE];
    logic [63:0] sh_nlo [TSIZE];
    logic [47:0] sh_nhi [TSIZE];
    int          sh_used;
    logic [31:0] sh_root;
    logic [3:0]  sh_depth;

    result_t expected_results[$];
    int      mismatches;
    int      req_gap_max;
    int      rsp_stall_max;
    logic [31:0] known_keys[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("FAIL");
        $finish;
    end

    // 1: found, 0: empty slot, -1: no empty slot
    function automatic int probe_slot(input logic [31:0] k, output int slot);
        int idx;
        idx = k & (TSIZE - 1);
        for (int n = 0; n < TSIZE; n++)
        begin
            if (sh_key[idx] == 0)
            begin
                slot = idx;
                return 0;
            end
            if (sh_key[idx] == k)
            begin
                slot = idx;
                return 1;
            end
            idx = (idx + 1) & (TSIZE - 1);
        end
        slot = 0;
        return -1;
    endfunction

    function automatic result_t mk(input logic [1:0] kind, input logic [1:0] st,
                                   input logic [31:0] p, input logic [63:0] lo,
                                   input logic [47:0] hi, input logic lst);
        result_t r;
        r.kind = kind;
        r.status = st;
        r.parent = p;
        r.nlo = lo;
        r.nhi = hi;
        r.last = lst;
        return r;
    endfunction

    // apply one request to the shadow table and queue its results
    task automatic predict_request(input logic [1:0] f, input logic [31:0] k,
                                   input logic [31:0] p, input logic [63:0] lo,
                                   input logic [47:0] hi);
        int slot;
        int r;
        int chain[$];
        int lim;
        int lev;
        logic [31:0] cur;
        logic [1:0] marker;
        chain = {};
        if (f == FUNC_WALK)
        begin
            lim = (sh_depth > MAX_DEPTH) ? MAX_DEPTH : sh_depth;
            cur = k;
            lev = 0;
            marker = KIND_STATUS;
            forever
            begin
                if (cur == sh_root)
                    break;
                if (cur == 0 || probe_slot(cur, slot) != 1)
                begin
                    marker = KIND_UNKNOWN;
                    break;
                end
                if (lev > lim)
                begin
                    marker = KIND_TRUNC;
                    break;
                end
                chain.push_back(slot);
                cur = sh_par[slot];
                lev++;
            end
            if (marker != KIND_STATUS)
                expected_results.push_back(mk(marker, STAT_OK, '0, '0, '0, 1'b0));
            for (int i = chain.size() - 1; i >= 0; i--)
                expected_results.push_back(mk(KIND_COMP, STAT_OK, '0, sh_nlo[chain[i]],
                                              sh_nhi[chain[i]], 1'b0));
            expected_results.push_back(mk(KIND_STATUS, (marker == KIND_UNKNOWN) ?
                                          STAT_NOTFOUND : STAT_OK, '0, '0, '0, 1'b1));
            return;
        end
        if (k == 0)
        begin
            expected_results.push_back(mk(KIND_STATUS, STAT_ZEROKEY, '0, '0, '0, 1'b1));
            return;
        end
        r = probe_slot(k, slot);
        if (f == FUNC_INSERT)
        begin
            if (r == 1)
                expected_results.push_back(mk(KIND_STATUS, STAT_OK, sh_par[slot],
                                              sh_nlo[slot], sh_nhi[slot], 1'b1));
            else if (r < 0 || sh_used + 1 >= TSIZE)
                expected_results.push_back(mk(KIND_STATUS, STAT_FULL, '0, '0, '0, 1'b1));
            else
            begin
                sh_key[slot] = k;
                sh_par[slot] = '0;
                sh_nlo[slot] = '0;
                sh_nhi[slot] = '0;
                sh_used++;
                known_keys.push_back(k);
                expected_results.push_back(mk(KIND_STATUS, STAT_OK, '0, '0, '0, 1'b1));
            end
            return;
        end
        if (r != 1)
        begin
            expected_results.push_back(mk(KIND_STATUS, STAT_NOTFOUND, '0, '0, '0, 1'b1));
            return;
        end
        if (f == FUNC_SET)
        begin
            sh_par[slot] = p;
            sh_nlo[slot] = lo;
            sh_nhi[slot] = hi;
        end
        expected_results.push_back(mk(KIND_STATUS, STAT_OK, sh_par[slot],
                                      sh_nlo[slot], sh_nhi[slot], 1'b1));
    endtask

    function automatic int pick_gap(input int maxlong);
        if ($urandom_range(0, 9) < 4)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, maxlong);
    endfunction

    // send one request and predict it at acceptance
    task automatic send_request(input logic [1:0] f, input logic [31:0] k,
                                input logic [31:0] p, input logic [63:0] lo,
                                input logic [47:0] hi);
        int g;
        g = (req_gap_max == 0) ? 0 : pick_gap(req_gap_max);
        if (g != 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func <= f;
        req.key <= k;
        req.parent_in <= p;
        req.name_low_in <= lo;
        req.name_high_in <= hi;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_request(f, k, p, lo, hi);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ROOT)
            sh_root = v;
        else
            sh_depth = v[3:0];
        @(posedge clk);
    endtask

    // result side: random stall and compare against the oldest expectation
    initial
    begin
        result_t got;
        result_t want;
        int s;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            s = (rsp_stall_max == 0) ? 0 : pick_gap(rsp_stall_max);
            if (s != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (s) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got = mk(rsp.kind, rsp.status, rsp.parent_out, rsp.name_low_out,
                         rsp.name_high_out, rsp.last);
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
    end

    // directed rows, fixed values checked directly when has_exp is set
    row_t dir_rows[$];

    function automatic row_t row(input logic [1:0] f, input logic [31:0] k,
                                 input logic [31:0] p, input logic [63:0] lo,
                                 input logic [47:0] hi);
        row_t r;
        r.func = f;
        r.key = k;
        r.parent = p;
        r.nlo = lo;
        r.nhi = hi;
        r.has_exp = 1'b0;
        r.exp = '0;
        return r;
    endfunction

    function automatic row_t row_x(input logic [1:0] f, input logic [31:0] k,
                                   input logic [1:0] st);
        row_t r;
        r = row(f, k, '0, '0, '0);
        r.has_exp = 1'b1;
        r.exp = mk(KIND_STATUS, st, '0, '0, '0, 1'b1);
        return r;
    endfunction

    initial
    begin
        logic [1:0] f;
        logic [31:0] k;
        logic [31:0] p;
        int n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROOT;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.func = FUNC_INSERT;
        req.key = '0;
        req.parent_in = '0;
        req.name_low_in = '0;
        req.name_high_in = '0;
        mismatches = 0;
        req_gap_max = 12;
        rsp_stall_max = 12;
        sh_used = 0;
        sh_root = 2;
        sh_depth = 10;
        for (int i = 0; i < TSIZE; i++)
        begin
            sh_key[i] = '0;
            sh_par[i] = '0;
            sh_nlo[i] = '0;
            sh_nhi[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: empty table, zero keys, extremes, collisions, walks, cycle
        dir_rows.push_back(row_x(FUNC_LOOKUP, 32'd5, STAT_NOTFOUND));
        dir_rows.push_back(row_x(FUNC_SET, 32'd5, STAT_NOTFOUND));
        dir_rows.push_back(row_x(FUNC_INSERT, 32'd0, STAT_ZEROKEY));
        dir_rows.push_back(row_x(FUNC_LOOKUP, 32'd0, STAT_ZEROKEY));
        dir_rows.push_back(row_x(FUNC_SET, 32'd0, STAT_ZEROKEY));
        dir_rows.push_back(row_x(FUNC_INSERT, 32'hFFFF_FFFF, STAT_OK));
        dir_rows.push_back(row_x(FUNC_INSERT, 32'h0000_0FFF, STAT_OK));
        dir_rows.push_back(row_x(FUNC_INSERT, 32'h0000_1FFF, STAT_OK));
        dir_rows.push_back(row(FUNC_SET, 32'hFFFF_FFFF, 32'd2, '1, '1));
        dir_rows.push_back(row(FUNC_SET, 32'h0000_1FFF, 32'hFFFF_FFFF,
                               64'h0123_4567_89AB_CDEF, 48'hA5A5_5A5A_0F0F));
        dir_rows.push_back(row(FUNC_INSERT, 32'h0000_1FFF, '0, '0, '0));
        dir_rows.push_back(row(FUNC_LOOKUP, 32'h0000_0FFF, '0, '0, '0));
        dir_rows.push_back(row(FUNC_WALK, 32'h0000_1FFF, '0, '0, '0));
        dir_rows.push_back(row(FUNC_WALK, 32'd2, '0, '0, '0));
        dir_rows.push_back(row(FUNC_WALK, 32'd0, '0, '0, '0));
        dir_rows.push_back(row(FUNC_WALK, 32'h0000_0FFF, '0, '0, '0));
        dir_rows.push_back(row(FUNC_INSERT, 32'd7, '0, '0, '0));
        dir_rows.push_back(row(FUNC_SET, 32'd7, 32'd7, 64'h6c6f6f70, 48'h1));
        dir_rows.push_back(row(FUNC_WALK, 32'd7, '0, '0, '0));
        dir_rows.push_back(row(FUNC_SET, 32'h0000_0FFF, 32'h0000_1FFF, '0, '0));
        dir_rows.push_back(row(FUNC_WALK, 32'h0000_0FFF, '0, '0, '0));
        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i].func, dir_rows[i].key, dir_rows[i].parent,
                         dir_rows[i].nlo, dir_rows[i].nhi);
            if (dir_rows[i].has_exp && expected_results[$] !== dir_rows[i].exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: predictor disagrees with typed result", i);
            end
        end

        // hold the sender until every expected result is back
        drain_results();

        // random part over several register settings, extremes included
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin write_reg(CFG_DEPTH, 32'd0); write_reg(CFG_ROOT, 32'hFFFF_FFFF); end
                1: begin write_reg(CFG_DEPTH, 32'd15); write_reg(CFG_ROOT, 32'd1); end
                2: begin write_reg(CFG_DEPTH, 32'd3); write_reg(CFG_ROOT, 32'd2); end
                default: begin write_reg(CFG_DEPTH, 32'd10); write_reg(CFG_ROOT, 32'd7); end
            endcase
            req_gap_max = (phase == 2) ? 0 : 20;
            rsp_stall_max = (phase == 2) ? 0 : 20;
            for (int i = 0; i < 25; i++)
            begin
                f = 2'($urandom_range(0, 3));
                n = $urandom_range(0, 9);
                if (n < 5 && known_keys.size() != 0)
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else if (n < 8)
                    k = $urandom_range(1, 40) + ($urandom_range(0, 3) << 12);
                else if (n == 8)
                    k = $urandom();
                else
                    k = '0;
                if (known_keys.size() != 0 && $urandom_range(0, 3) != 0)
                    p = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else
                    p = ($urandom_range(0, 1) != 0) ? sh_root : $urandom();
                send_request(f, k, p, {$urandom(), $urandom()},
                             {16'($urandom()), $urandom()});
            end
            drain_results();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
